FILE: sv/utf8v_pkg.sv
// Shared types, constants and byte classification functions for the UTF-8 validator.
package utf8v_pkg;

    localparam int IndexBits = 32;
    localparam int OutBits   = 32;

    typedef enum logic [1:0] {
        StatusValid      = 2'd0,
        StatusInvalid    = 2'd1,
        StatusIncomplete = 2'd2
    } t_status;

    typedef struct packed {
        logic [IndexBits-1:0] byte_index;
        logic [IndexBits-1:0] sequence_start;
        logic [7:0]           lead_value;
        logic [2:0]           sequence_width;
        logic [1:0]           bytes_seen;
        logic                 error_reported;
    } t_state;

    typedef struct packed {
        logic               has_result;
        t_status            status;
        logic [1:0]         error_length;
        logic [OutBits-1:0] prefix_len;
    } t_result;

    localparam t_state StateReset = '{
        byte_index:     '0,
        sequence_start: '0,
        lead_value:     8'h00,
        sequence_width: 3'd0,
        bytes_seen:     2'd0,
        error_reported: 1'b0
    };

    function automatic logic is_continuation(input logic [7:0] x);
        return (x & 8'hC0) == 8'h80;
    endfunction

    // 0 marks a byte that cannot start a sequence
    function automatic logic [2:0] lead_width(input logic [7:0] x);
        logic [2:0] w;
        if (x < 8'h80) begin
            w = 3'd1;
        end else if (x >= 8'hC2 && x <= 8'hDF) begin
            w = 3'd2;
        end else if (x >= 8'hE0 && x <= 8'hEF) begin
            w = 3'd3;
        end else if (x >= 8'hF0 && x <= 8'hF4) begin
            w = 3'd4;
        end else begin
            w = 3'd0;
        end
        return w;
    endfunction

    // second byte ranges exclude overlongs, surrogates and code points past U+10FFFF
    function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] x);
        logic ok;
        if (lead >= 8'hC2 && lead <= 8'hDF) begin
            ok = is_continuation(x);
        end else if (lead == 8'hE0) begin
            ok = (x >= 8'hA0) && (x <= 8'hBF);
        end else if (lead == 8'hED) begin
            ok = (x >= 8'h80) && (x <= 8'h9F);
        end else if (lead >= 8'hE1 && lead <= 8'hEF) begin
            ok = is_continuation(x);
        end else if (lead == 8'hF0) begin
            ok = (x >= 8'h90) && (x <= 8'hBF);
        end else if (lead == 8'hF4) begin
            ok = (x >= 8'h80) && (x <= 8'h8F);
        end else if (lead >= 8'hF1 && lead <= 8'hF3) begin
            ok = is_continuation(x);
        end else begin
            ok = 1'b0;
        end
        return ok;
    endfunction

    // low OutBits of an index, zero-extended when the index is narrower
    function automatic logic [OutBits-1:0] to_out(input logic [IndexBits-1:0] idx);
        logic [IndexBits+OutBits-1:0] ext;
        ext = {{OutBits{1'b0}}, idx};
        return ext[OutBits-1:0];
    endfunction

endpackage

FILE: sv/utf8v_step.sv
// Next-state and result logic for one byte of the validator.
module utf8v_step (
    input  utf8v_pkg::t_state  i_state,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    output utf8v_pkg::t_state  o_state,
    output utf8v_pkg::t_result o_result
);

    always_comb begin
        utf8v_pkg::t_state          s;
        logic [1:0]                 err_len;
        logic [utf8v_pkg::IndexBits-1:0] err_at;
        logic [utf8v_pkg::IndexBits-1:0] idx_inc;
        logic [2:0]                 w;
        logic                       ok;
        logic [1:0]                 seen_inc;

        s        = i_state;
        err_len  = 2'd0;
        err_at   = '0;
        idx_inc  = i_state.byte_index + 1'b1;
        w        = utf8v_pkg::lead_width(i_data_byte);
        ok       = (i_state.bytes_seen == 2'd1)
                 ? utf8v_pkg::second_ok(i_state.lead_value, i_data_byte)
                 : utf8v_pkg::is_continuation(i_data_byte);
        seen_inc = i_state.bytes_seen + 2'd1;

        o_result.has_result   = 1'b0;
        o_result.status       = utf8v_pkg::StatusValid;
        o_result.error_length = 2'd0;
        o_result.prefix_len   = utf8v_pkg::to_out(idx_inc);

        if (i_state.error_reported) begin
            // swallow until the buffer ends
            s.byte_index = idx_inc;
            if (i_last_byte) begin
                s = utf8v_pkg::StateReset;
            end
        end else begin
            if (i_state.sequence_width == 3'd0) begin
                if (w == 3'd0) begin
                    err_len = 2'd1;
                    err_at  = i_state.byte_index;
                end else if (w > 3'd1) begin
                    s.sequence_start = i_state.byte_index;
                    s.lead_value     = i_data_byte;
                    s.sequence_width = w;
                    s.bytes_seen     = 2'd1;
                end
            end else begin
                if (!ok) begin
                    err_len = i_state.bytes_seen;
                    err_at  = i_state.sequence_start;
                end else begin
                    s.bytes_seen = seen_inc;
                    if (seen_inc == 2'd0 || {1'b0, seen_inc} >= i_state.sequence_width) begin
                        s.sequence_width = 3'd0;
                        s.bytes_seen     = 2'd0;
                    end
                end
            end
            s.byte_index = idx_inc;

            if (err_len != 2'd0) begin
                o_result.has_result   = 1'b1;
                o_result.status       = utf8v_pkg::StatusInvalid;
                o_result.error_length = err_len;
                o_result.prefix_len   = utf8v_pkg::to_out(err_at);
                if (i_last_byte) begin
                    s = utf8v_pkg::StateReset;
                end else begin
                    s.error_reported = 1'b1;
                end
            end else if (i_last_byte) begin
                o_result.has_result = 1'b1;
                if (s.sequence_width != 3'd0) begin
                    o_result.status     = utf8v_pkg::StatusIncomplete;
                    o_result.prefix_len = utf8v_pkg::to_out(s.sequence_start);
                end
                s = utf8v_pkg::StateReset;
            end
        end

        o_state = s;
    end

endmodule

FILE: sv/utf8_stream_validator_core.sv
// Top level of the UTF-8 stream validator: input register, step logic, result register.
// Order: a byte is registered on acceptance and its result, if any, is registered in the
// result register, which drives o_out_valid, when the step logic processes that byte.
// Throughput: one byte per cycle; the input register and the result register part the
// two channels, and a result left waiting stalls the bytes behind it until it is taken.
// Reset (i_rst_n low, synchronous): both registers empty, validator state cleared.
module utf8_stream_validator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output logic [1:0]  o_status,
    output logic [1:0]  o_error_length,
    output logic [31:0] o_prefix_len,
    input  logic        i_out_stall
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_last;
    utf8v_pkg::t_state  r_state;
    utf8v_pkg::t_state  n_state;
    utf8v_pkg::t_result step_result;
    logic               r_out_valid;
    logic [1:0]         r_status;
    logic [1:0]         r_error_length;
    logic [31:0]        r_prefix_len;
    logic               out_free;
    logic               proc;
    logic               in_take;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    utf8v_step u_step (
        .i_state     (r_state),
        .i_data_byte (r_in_byte),
        .i_last_byte (r_in_last),
        .o_state     (n_state),
        .o_result    (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= utf8v_pkg::StateReset;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (proc) begin
                r_state <= n_state;
            end
            if (out_free) begin
                r_out_valid <= proc && step_result.has_result;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
        if (proc && step_result.has_result) begin
            r_status       <= step_result.status;
            r_error_length <= step_result.error_length;
            r_prefix_len   <= step_result.prefix_len;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_error_length = r_error_length;
    assign o_prefix_len   = r_prefix_len;

    a_len_matches_status : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_status == utf8v_pkg::StatusInvalid) == (o_error_length != 2'd0)))
        else $error("error length disagrees with status");

    a_reset_after_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && r_in_last) |=> (r_state.byte_index == '0 && r_state.sequence_width == 3'd0
                                 && !r_state.error_reported))
        else $error("state not cleared after final byte");

    a_no_seq_no_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.sequence_width == 3'd0) |-> (r_state.bytes_seen == 2'd0))
        else $error("bytes counted with no open sequence");

    a_early_result_sets_error : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && step_result.has_result && !r_in_last) |=> r_state.error_reported)
        else $error("mid-buffer result without error flag");

endmodule

FILE: dv/utf8_result_checker.sv
// Checker for the UTF-8 stream validator: watches both channels, predicts verdicts, compares.
module utf8_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_status,
    input  logic [1:0]  i_error_length,
    input  logic [31:0] i_prefix_len,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        utf8v_pkg::t_status status;
        logic [1:0]         err_len;
        logic [31:0]        up_to;
    } t_verdict;

    t_verdict verdict_q[$];

    // decoder state
    logic [31:0] pos;
    logic [31:0] seq_origin;
    logic [7:0]  lead;
    logic [2:0]  span;
    logic [1:0]  taken;
    logic        spoiled;

    int fail_total    = 0;
    int pending_total = 0;
    int checked_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;
    assign o_checked    = checked_total;

    function automatic logic [2:0] span_of(input logic [7:0] b);
        if (b[7] == 1'b0) return 3'd1;
        if (b >= 8'hC2 && b <= 8'hDF) return 3'd2;
        if (b[7:4] == 4'hE) return 3'd3;
        if (b >= 8'hF0 && b <= 8'hF4) return 3'd4;
        return 3'd0;
    endfunction

    // window for the byte after the lead; narrowed for overlong, surrogate and >U+10FFFF
    function automatic logic second_fits(input logic [7:0] ld, input logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = 8'h80;
        hi = 8'hBF;
        case (ld)
            8'hE0: lo = 8'hA0;
            8'hED: hi = 8'h9F;
            8'hF0: lo = 8'h90;
            8'hF4: hi = 8'h8F;
            default: ;
        endcase
        return (b >= lo) && (b <= hi);
    endfunction

    task automatic clear_decoder();
        pos        = '0;
        seq_origin = '0;
        lead       = '0;
        span       = '0;
        taken      = '0;
        spoiled    = 1'b0;
    endtask

    task automatic expect_verdict(input utf8v_pkg::t_status s, input logic [1:0] len,
                                  input logic [31:0] at);
        t_verdict v;
        v.status  = s;
        v.err_len = len;
        v.up_to   = at;
        verdict_q.push_back(v);
    endtask

    task automatic take_byte(input logic [7:0] b, input logic last);
        logic [1:0]  bad_len;
        logic [31:0] bad_at;
        logic [2:0]  w;
        logic        ok;
        bad_len = '0;
        bad_at  = '0;
        if (spoiled) begin
            if (last) clear_decoder();
            else pos = pos + 32'd1;
            return;
        end
        if (span == 3'd0) begin
            w = span_of(b);
            if (w == 3'd0) begin
                bad_len = 2'd1;
                bad_at  = pos;
            end else if (w > 3'd1) begin
                seq_origin = pos;
                lead       = b;
                span       = w;
                taken      = 2'd1;
            end
        end else begin
            ok = (taken == 2'd1) ? second_fits(lead, b) : (b[7:6] == 2'b10);
            if (!ok) begin
                bad_len = taken;
                bad_at  = seq_origin;
            end else begin
                // 2-bit count wraps to 0 when a 4-byte sequence completes
                taken = taken + 2'd1;
                if (taken == 2'd0 || {1'b0, taken} >= span) begin
                    span  = '0;
                    taken = '0;
                end
            end
        end
        pos = pos + 32'd1;
        if (bad_len != 2'd0) begin
            expect_verdict(utf8v_pkg::StatusInvalid, bad_len, bad_at);
            if (last) clear_decoder();
            else spoiled = 1'b1;
        end else if (last) begin
            if (span != 3'd0) expect_verdict(utf8v_pkg::StatusIncomplete, 2'd0, seq_origin);
            else expect_verdict(utf8v_pkg::StatusValid, 2'd0, pos);
            clear_decoder();
        end
    endtask

    task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
        fail_total++;
        if (fail_total <= 40)
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    endtask

    task automatic check_result();
        t_verdict want;
        if (verdict_q.size() == 0) begin
            fail_total++;
            if (fail_total <= 40)
                $display("%0t: result with none expected: expected nothing, actual %0d/%0d/%0d",
                         $time, i_status, i_error_length, i_prefix_len);
            return;
        end
        want = verdict_q.pop_front();
        checked_total++;
        if (i_status !== want.status)
            report("status", 32'(want.status), 32'(i_status));
        if (i_error_length !== want.err_len)
            report("error_length", 32'(want.err_len), 32'(i_error_length));
        if (i_prefix_len !== want.up_to) report("prefix_len", want.up_to, i_prefix_len);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_decoder();
            verdict_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) take_byte(i_data_byte, i_last_byte);
            if (i_out_valid && !i_out_stall) check_result();
        end
        pending_total = verdict_q.size();
    end

endmodule

FILE: dv/utf8_stream_validator_core_test.sv
// Top of the UTF-8 validator testbench: clock, reset, byte stream stimulus and verdict.
module utf8_stream_validator_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ByteTarget = 1250;
    localparam int CycleLimit = 200000;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [7:0]  i_data_byte    = 8'h00;
    logic        i_last_byte    = 1'b0;
    logic        i_out_stall    = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_status;
    logic [1:0]  o_error_length;
    logic [31:0] o_prefix_len;

    int fail_count;
    int pending;
    int checked;

    bit          calm           = 1'b0;
    int          bytes_sent     = 0;
    int          buffers_sent   = 0;
    int unsigned cycle_count    = 0;
    logic [7:0]  text_q[$];

    // bytes near the range limits of leads and second bytes
    logic [7:0] ragged_bytes [14] = '{8'h00, 8'h7F, 8'h80, 8'h8F, 8'h90, 8'h9F, 8'hA0,
                                      8'hBF, 8'hC0, 8'hC1, 8'hC2, 8'hF4, 8'hF5, 8'hFF};

    utf8_stream_validator_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .o_in_stall     (o_in_stall),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_error_length (o_error_length),
        .o_prefix_len   (o_prefix_len),
        .i_out_stall    (i_out_stall)
    );

    utf8_result_checker checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_status       (o_status),
        .i_error_length (o_error_length),
        .i_prefix_len   (o_prefix_len),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(0, 99) < 12);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!calm && $urandom_range(0, 99) < 12) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
        buffers_sent++;
        text_q.delete();
    endtask

    // hold off the sender until every predicted verdict has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic logic [7:0] pick_second(input logic [7:0] ld);
        case (ld)
            8'hE0:   return 8'($urandom_range(8'hA0, 8'hBF));
            8'hED:   return 8'($urandom_range(8'h80, 8'h9F));
            8'hF0:   return 8'($urandom_range(8'h90, 8'hBF));
            8'hF4:   return 8'($urandom_range(8'h80, 8'h8F));
            default: return 8'($urandom_range(8'h80, 8'hBF));
        endcase
    endfunction

    function automatic logic [7:0] pick_ragged();
        if ($urandom_range(0, 3) == 0) return 8'($urandom);
        return ragged_bytes[$urandom_range(0, 13)];
    endfunction

    // appends one well-formed character of at least min_w bytes, returns its width
    task automatic append_char(input int min_w, output int w);
        logic [7:0] ld;
        w = $urandom_range(min_w, 4);
        case (w)
            1: ld = 8'($urandom_range(0, 8'h7F));
            2: ld = 8'($urandom_range(8'hC2, 8'hDF));
            3: begin
                if ($urandom_range(0, 2) == 0) ld = $urandom_range(0, 1) ? 8'hE0 : 8'hED;
                else ld = 8'($urandom_range(8'hE0, 8'hEF));
            end
            default: begin
                if ($urandom_range(0, 1) == 0) ld = $urandom_range(0, 1) ? 8'hF0 : 8'hF4;
                else ld = 8'($urandom_range(8'hF0, 8'hF4));
            end
        endcase
        text_q.push_back(ld);
        if (w > 1) text_q.push_back(pick_second(ld));
        for (int i = 2; i < w; i++) text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
    endtask

    task automatic append_chars(input int n);
        int w;
        repeat (n) append_char(1, w);
    endtask

    task automatic build_buffer();
        int mode;
        int w;
        int spot;
        mode = $urandom_range(0, 99);
        if (mode < 90)
            append_chars(($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 6));
        if (mode >= 60 && mode < 72) begin
            // cut the buffer off inside a sequence
            append_char(2, w);
            repeat ($urandom_range(1, w - 1)) void'(text_q.pop_back());
        end else if (mode >= 72 && mode < 90) begin
            spot = $urandom_range(0, text_q.size() - 1);
            text_q[spot] = pick_ragged();
            if ($urandom_range(0, 1) == 0) append_chars($urandom_range(1, 4));
        end else if (mode >= 90) begin
            repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom));
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed buffers; index wrap needs 2^32 bytes and is left out
        text_q = '{8'h00};                      send_text();  // single ASCII, valid
        text_q = '{8'hFF};                      send_text();  // bad lead on final byte
        text_q = '{8'h80, 8'h41, 8'h7F};        send_text();  // stray continuation, swallow
        text_q = '{8'hE0, 8'h9F};               send_text();  // overlong 3-byte form
        text_q = '{8'hED, 8'hA0, 8'h01};        send_text();  // surrogate
        text_q = '{8'hF4, 8'h8F, 8'h41};        send_text();  // bad third byte
        text_q = '{8'hF0, 8'h90, 8'h80, 8'hC0}; send_text();  // bad fourth byte
        text_q = '{8'hDF, 8'hBF, 8'hE1};        send_text();  // ends inside a sequence
        text_q = '{8'hC1};                      send_text();  // overlong 2-byte lead
        text_q = '{8'hF5};                      send_text();  // lead past U+10FFFF
        drain();

        while (bytes_sent < ByteTarget) begin
            calm = (bytes_sent >= 500 && bytes_sent < 700);
            build_buffer();
            send_text();
            if ($urandom_range(0, 39) == 0) drain();
        end
        calm = 1'b0;
        drain();
        repeat (8) @(posedge i_clk);

        $display("Sent %0d bytes in %0d buffers; %0d verdicts compared, %0d mismatches.",
                 bytes_sent, buffers_sent, checked, fail_count);
        $display("Mix: well-formed text, truncated tails, corrupted bytes, raw noise, stalls.");
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
